// ===== rtl/core/gradient_color_ramp_lookup_macros.svh =====
// Assertion macros for the gradient color ramp lookup block.
`ifndef GRADIENT_COLOR_RAMP_LOOKUP_MACROS_SVH
`define GRADIENT_COLOR_RAMP_LOOKUP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define GCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcr: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define GCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcr: next-cycle check failed");

`endif

// ===== rtl/core/gcr_pkg.sv =====
// Shared types, constants and codes of the gradient color ramp lookup block.
package gcr_pkg;

	localparam int MaxStops   = 16;
	localparam int FracBits   = 16;
	localparam int PosW       = FracBits + 1;
	localparam int AddrW      = $clog2(MaxStops);
	localparam int CountW     = 5;
	localparam int CoordW     = 16;
	localparam int ChanW      = 8;
	localparam int ChanShW    = $clog2(ChanW);
	localparam int NumChan    = 4;
	localparam int RemW       = CoordW + FracBits;
	localparam int ShW        = $clog2(FracBits);
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 17;

	localparam logic [PosW-1:0] RampOne = {1'b1, {FracBits{1'b0}}};

	typedef logic [NumChan-1:0][ChanW-1:0] color_t;

	typedef struct packed {
		logic [PosW-1:0] pos;
		color_t          color;
	} stop_t;

	typedef struct packed {
		logic               action;
		logic [3:0]         stop_index;
		logic [16:0]        stop_position;
		logic [7:0]         stop_red;
		logic [7:0]         stop_green;
		logic [7:0]         stop_blue;
		logic [7:0]         stop_alpha;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
	} item_t;

	typedef struct packed {
		logic [16:0] ramp_position;
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [7:0]  out_alpha;
	} result_t;

	typedef struct packed {
		logic [1:0]         ramp_mode;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        size_x;
		logic [15:0]        size_y;
		logic [16:0]        value_position;
		logic [4:0]         stop_count;
		logic               texture_valid;
	} cfg_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} act_t;

	typedef enum logic [1:0] {
		MODE_HORIZ = 2'd0,
		MODE_VERT  = 2'd1,
		MODE_VALUE = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RAMP_MODE      = 3'd0,
		CFG_ORIGIN_X       = 3'd1,
		CFG_ORIGIN_Y       = 3'd2,
		CFG_SIZE_X         = 3'd3,
		CFG_SIZE_Y         = 3'd4,
		CFG_VALUE_POSITION = 3'd5,
		CFG_STOP_COUNT     = 3'd6,
		CFG_TEXTURE_VALID  = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_DIVPOS,
		S_LOOKUP,
		S_FETCH,
		S_SCAN,
		S_MULA,
		S_MULB,
		S_DIVCH,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/core/gradient_color_ramp_lookup.sv =====
// Top level of the gradient color ramp lookup: registers, stop table and sequencer.
//
// Channels: an item is accepted when start is high and busy is low. A stop-write
// transaction stores one color stop in the table in that cycle; busy stays low and
// no result follows. A query transaction raises busy; its result appears on the
// result port for exactly one cycle with done high, and busy drops the cycle after.
// The receiver cannot stall: the result is taken at the edge that ends that cycle.
// Query steps from the accepting edge to the done cycle, one shared compare and
// subtract unit doing all division steps: setup, 16 position division steps (axis
// modes, inside the rectangle only), lookup, table fetch (nonempty table), stop
// scan, 4 x (2 multiply + 8 division steps) when interpolating, result. A new item
// is accepted in the cycle after done. Registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only while
// idle, which the block does not enforce. cfg_ready is always high. Reset clears
// the registers to their defaults and idles the sequencer; stop table contents
// are undefined until written.
`include "gradient_color_ramp_lookup_macros.svh"

module gradient_color_ramp_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  gcr_pkg::item_t                item,
	output logic                          done,
	output gcr_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gcr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [gcr_pkg::CfgDataW-1:0]  cfg_data
);

	gcr_pkg::cfg_t             cfg_q;
	gcr_pkg::stop_t            wr_stop, rd_stop;
	logic                      wr_en;
	logic [gcr_pkg::AddrW-1:0] rd_addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_mode      <= gcr_pkg::MODE_VALUE;
			cfg_q.origin_x       <= '0;
			cfg_q.origin_y       <= '0;
			cfg_q.size_x         <= 16'd1;
			cfg_q.size_y         <= 16'd1;
			cfg_q.value_position <= '0;
			cfg_q.stop_count     <= '0;
			cfg_q.texture_valid  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gcr_pkg::CFG_RAMP_MODE:      cfg_q.ramp_mode      <= cfg_data[1:0];
				gcr_pkg::CFG_ORIGIN_X:       cfg_q.origin_x       <= cfg_data[15:0];
				gcr_pkg::CFG_ORIGIN_Y:       cfg_q.origin_y       <= cfg_data[15:0];
				gcr_pkg::CFG_SIZE_X:         cfg_q.size_x         <= cfg_data[15:0];
				gcr_pkg::CFG_SIZE_Y:         cfg_q.size_y         <= cfg_data[15:0];
				gcr_pkg::CFG_VALUE_POSITION: cfg_q.value_position <= cfg_data[16:0];
				gcr_pkg::CFG_STOP_COUNT:     cfg_q.stop_count     <= cfg_data[4:0];
				gcr_pkg::CFG_TEXTURE_VALID:  cfg_q.texture_valid  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		wr_en = start && !busy && item.action == gcr_pkg::ACT_WRITE
		     && 32'(item.stop_index) < gcr_pkg::MaxStops;
		wr_stop.pos   = item.stop_position;
		wr_stop.color = {item.stop_alpha, item.stop_blue, item.stop_green, item.stop_red};
	end

	gcr_ram #(
		.Width ($bits(gcr_pkg::stop_t)),
		.Depth (gcr_pkg::MaxStops)
	) u_stop_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item.stop_index[gcr_pkg::AddrW-1:0]),
		.wdata (wr_stop),
		.raddr (rd_addr),
		.rdata (rd_stop)
	);

	gcr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.cfg    (cfg_q),
		.rdata  (rd_stop),
		.raddr  (rd_addr),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	`GCR_ASSERT_NEXT(a_write_stays_idle, start && !busy && item.action == gcr_pkg::ACT_WRITE, !busy && !done)
	`GCR_ASSERT_NEXT(a_query_goes_busy, start && !busy && item.action == gcr_pkg::ACT_QUERY, busy)
	`GCR_ASSERT_NEXT(a_done_single, done, !done && !busy)
	`GCR_ASSERT_NOW(a_done_in_range, done, busy && result.ramp_position <= gcr_pkg::RampOne)

endmodule

// ===== rtl/core/gcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gcr_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/gcr_div_step.sv =====
// One restoring-division step: compare against the shifted divisor and subtract.
module gcr_div_step (
	input  logic [gcr_pkg::RemW-1:0] rem,
	input  logic [gcr_pkg::PosW-1:0] divisor,
	input  logic [gcr_pkg::ShW-1:0]  shamt,
	output logic [gcr_pkg::RemW-1:0] rem_next,
	output logic                     q_bit
);

	logic [gcr_pkg::RemW:0] trial;

	always_comb begin
		trial    = (gcr_pkg::RemW + 1)'(divisor) << shamt;
		q_bit    = {1'b0, rem} >= trial;
		rem_next = q_bit ? rem - trial[gcr_pkg::RemW-1:0] : rem;
	end

endmodule

// ===== rtl/core/gcr_engine.sv =====
// Query sequencer: ramp position, stop search and channel interpolation.
module gcr_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  gcr_pkg::item_t            item,
	input  gcr_pkg::cfg_t             cfg,
	input  gcr_pkg::stop_t            rdata,
	output logic [gcr_pkg::AddrW-1:0] raddr,
	output logic                      busy,
	output logic                      done,
	output gcr_pkg::result_t          result
);

	gcr_pkg::state_t state_q, state_d;

	logic signed [gcr_pkg::CoordW-1:0] coord_q;
	logic [gcr_pkg::PosW-1:0]          where_q;
	logic [gcr_pkg::RemW-1:0]          acc_q;
	logic [gcr_pkg::ShW-1:0]           sh_q;
	logic [gcr_pkg::AddrW-1:0]         k_q, j_q, last_q;
	gcr_pkg::stop_t                    lo_q;
	gcr_pkg::color_t                   hi_col_q, col_q;
	logic [gcr_pkg::PosW-1:0]          span_q, off_q;
	logic [1:0]                        ch_q;

	logic                              is_vert, is_axis;
	logic signed [gcr_pkg::CoordW-1:0] origin_sel;
	logic [gcr_pkg::CoordW-1:0]        size_sel;
	logic [gcr_pkg::CoordW:0]          diff;
	logic                              nonpos, saturate;
	logic [gcr_pkg::PosW-1:0]          clamped;
	logic [gcr_pkg::CountW-1:0]        cnt_eff, cnt_m1;
	logic                              found;

	logic [gcr_pkg::PosW-1:0]          div_divisor;
	logic [gcr_pkg::RemW-1:0]          div_rem;
	logic                              div_q;

	logic [gcr_pkg::ChanW-1:0]         mul_a;
	logic [gcr_pkg::PosW-1:0]          mul_b;
	logic [gcr_pkg::ChanW+gcr_pkg::PosW-1:0] prod;

	always_comb begin
		is_vert    = cfg.ramp_mode == gcr_pkg::MODE_VERT;
		is_axis    = cfg.ramp_mode == gcr_pkg::MODE_HORIZ || is_vert;
		origin_sel = is_vert ? cfg.origin_y : cfg.origin_x;
		size_sel   = is_vert ? cfg.size_y : cfg.size_x;
		diff       = {coord_q[gcr_pkg::CoordW-1], coord_q}
		           - {origin_sel[gcr_pkg::CoordW-1], origin_sel};
		nonpos     = diff[gcr_pkg::CoordW] || diff == '0;
		saturate   = diff[gcr_pkg::CoordW-1:0] >= size_sel;
		clamped    = (cfg.value_position > gcr_pkg::RampOne) ? gcr_pkg::RampOne
		                                                     : cfg.value_position;
		cnt_eff    = (cfg.stop_count > gcr_pkg::CountW'(gcr_pkg::MaxStops))
		           ? gcr_pkg::CountW'(gcr_pkg::MaxStops) : cfg.stop_count;
		cnt_m1     = cnt_eff - gcr_pkg::CountW'(1);
		found      = rdata.pos >= where_q;
	end

	always_comb begin
		div_divisor = (state_q == gcr_pkg::S_DIVPOS) ? gcr_pkg::PosW'(size_sel) : span_q;
		div_rem     = acc_q;
		mul_a       = (state_q == gcr_pkg::S_MULB) ? hi_col_q[ch_q] : lo_q.color[ch_q];
		mul_b       = (state_q == gcr_pkg::S_MULB) ? off_q : span_q - off_q;
		prod        = mul_a * mul_b;
	end

	logic [gcr_pkg::RemW-1:0] div_rem_next;

	gcr_div_step u_div_step (
		.rem      (div_rem),
		.divisor  (div_divisor),
		.shamt    (sh_q),
		.rem_next (div_rem_next),
		.q_bit    (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = state_q != gcr_pkg::S_IDLE;
		done    = state_q == gcr_pkg::S_EMIT;
		raddr   = k_q;
		case (state_q)
			gcr_pkg::S_IDLE: begin
				if (start && item.action == gcr_pkg::ACT_QUERY) begin
					state_d = gcr_pkg::S_SETUP;
				end
			end
			gcr_pkg::S_SETUP: begin
				if (is_axis && !nonpos && !saturate) begin
					state_d = gcr_pkg::S_DIVPOS;
				end else begin
					state_d = gcr_pkg::S_LOOKUP;
				end
			end
			gcr_pkg::S_DIVPOS: begin
				if (sh_q == '0) begin
					state_d = gcr_pkg::S_LOOKUP;
				end
			end
			gcr_pkg::S_LOOKUP: begin
				state_d = (cnt_eff == '0) ? gcr_pkg::S_EMIT : gcr_pkg::S_FETCH;
			end
			gcr_pkg::S_FETCH: begin
				state_d = gcr_pkg::S_SCAN;
			end
			gcr_pkg::S_SCAN: begin
				if (found) begin
					state_d = (j_q == '0) ? gcr_pkg::S_EMIT : gcr_pkg::S_MULA;
				end else if (j_q == last_q) begin
					state_d = gcr_pkg::S_EMIT;
				end
			end
			gcr_pkg::S_MULA: begin
				state_d = gcr_pkg::S_MULB;
			end
			gcr_pkg::S_MULB: begin
				state_d = gcr_pkg::S_DIVCH;
			end
			gcr_pkg::S_DIVCH: begin
				if (sh_q == '0) begin
					state_d = (ch_q == 2'(gcr_pkg::NumChan - 1)) ? gcr_pkg::S_EMIT
					                                              : gcr_pkg::S_MULA;
				end
			end
			gcr_pkg::S_EMIT: begin
				state_d = gcr_pkg::S_IDLE;
			end
			default: begin
				state_d = gcr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gcr_pkg::S_IDLE: begin
				coord_q <= (cfg.ramp_mode == gcr_pkg::MODE_VERT) ? item.point_y : item.point_x;
			end
			gcr_pkg::S_SETUP: begin
				acc_q   <= {diff[gcr_pkg::CoordW-1:0], {gcr_pkg::FracBits{1'b0}}};
				sh_q    <= gcr_pkg::ShW'(gcr_pkg::FracBits - 1);
				if (!is_axis) begin
					where_q <= clamped;
				end else if (!nonpos && saturate) begin
					where_q <= gcr_pkg::RampOne;
				end else begin
					where_q <= '0;
				end
			end
			gcr_pkg::S_DIVPOS: begin
				where_q[sh_q] <= div_q;
				acc_q         <= div_rem_next;
				sh_q          <= sh_q - gcr_pkg::ShW'(1);
			end
			gcr_pkg::S_LOOKUP: begin
				k_q    <= '0;
				last_q <= cnt_m1[gcr_pkg::AddrW-1:0];
				col_q  <= {(gcr_pkg::NumChan * gcr_pkg::ChanW){cfg.texture_valid}};
			end
			gcr_pkg::S_FETCH: begin
				j_q <= '0;
				k_q <= k_q + gcr_pkg::AddrW'(1);
			end
			gcr_pkg::S_SCAN: begin
				j_q      <= j_q + gcr_pkg::AddrW'(1);
				k_q      <= k_q + gcr_pkg::AddrW'(1);
				col_q    <= rdata.color;
				hi_col_q <= rdata.color;
				span_q   <= rdata.pos - lo_q.pos;
				off_q    <= where_q - lo_q.pos;
				ch_q     <= '0;
				if (!found || j_q == '0) begin
					lo_q <= rdata;
				end
			end
			gcr_pkg::S_MULA: begin
				acc_q <= gcr_pkg::RemW'(prod);
			end
			gcr_pkg::S_MULB: begin
				acc_q <= acc_q + gcr_pkg::RemW'(prod);
				sh_q  <= gcr_pkg::ShW'(gcr_pkg::ChanW - 1);
			end
			gcr_pkg::S_DIVCH: begin
				col_q[ch_q][sh_q[gcr_pkg::ChanShW-1:0]] <= div_q;
				acc_q <= div_rem_next;
				sh_q  <= sh_q - gcr_pkg::ShW'(1);
				if (sh_q == '0) begin
					ch_q <= ch_q + 2'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign result.ramp_position = where_q;
	assign result.out_red       = col_q[0];
	assign result.out_green     = col_q[1];
	assign result.out_blue      = col_q[2];
	assign result.out_alpha     = col_q[3];

endmodule

// ===== tb/tb_gradient_color_ramp_lookup.sv =====
// Self-checking testbench of the gradient color ramp lookup: directed table, then random phases.
module tb_gradient_color_ramp_lookup;
	import gcr_pkg::*;

	localparam int ItemTarget = 1100;
	localparam int QuietTail = 150;
	localparam int DrainCycles = 80;
	localparam int MaxPrinted = 60;
	localparam logic [1:0] ModeReserved = 2'd3;

	typedef enum {ROW_REG, ROW_STOP, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		cfg_idx_t            reg_idx;
		logic [CfgDataW-1:0] reg_val;
		item_t               it;
		bit                  known;
		result_t             want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	item_t               item;
	logic                done;
	result_t             result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cfg_t            ramp_regs;
	logic [PosW-1:0] stop_pos [MaxStops];
	logic [7:0]      stop_rgba [MaxStops][4];
	bit              stop_loaded [MaxStops];
	result_t         pending_colors [$];
	plan_row_t       plan [$];
	int              mismatches = 0;
	int              items_sent = 0;

	gradient_color_ramp_lookup i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint axis_ramp(logic [15:0] coord, logic [15:0] origin,
			logic [15:0] size);
		longint d;
		longint sz;
		d = longint'($signed(coord)) - longint'($signed(origin));
		sz = longint'(size);
		if (d <= 0)
			return 0;
		if (d >= sz)
			return longint'(RampOne);
		return (d << FracBits) / sz;
	endfunction

	function automatic result_t lookup_color(item_t it);
		longint where;
		longint span;
		longint off;
		longint a;
		longint b;
		int count;
		int lo;
		int hi;
		logic [7:0] chan [4];
		result_t r;
		case (ramp_regs.ramp_mode)
			MODE_HORIZ: where = axis_ramp(it.point_x, ramp_regs.origin_x, ramp_regs.size_x);
			MODE_VERT: where = axis_ramp(it.point_y, ramp_regs.origin_y, ramp_regs.size_y);
			default: where = (ramp_regs.value_position > RampOne) ? longint'(RampOne)
					: longint'(ramp_regs.value_position);
		endcase
		count = (ramp_regs.stop_count > MaxStops) ? MaxStops : int'(ramp_regs.stop_count);
		hi = -1;
		if (count == 0) begin
			for (int c = 0; c < 4; c++)
				chan[c] = ramp_regs.texture_valid ? 8'hff : 8'h00;
		end else if (longint'(stop_pos[0]) >= where) begin
			for (int c = 0; c < 4; c++)
				chan[c] = stop_rgba[0][c];
		end else begin
			for (int k = 1; k < count && hi < 0; k++)
				if (longint'(stop_pos[k]) >= where)
					hi = k;
			if (hi < 0) begin
				for (int c = 0; c < 4; c++)
					chan[c] = stop_rgba[count-1][c];
			end else begin
				lo = hi - 1;
				span = longint'(stop_pos[hi]) - longint'(stop_pos[lo]);
				off = where - longint'(stop_pos[lo]);
				for (int c = 0; c < 4; c++) begin
					a = longint'(stop_rgba[lo][c]);
					b = longint'(stop_rgba[hi][c]);
					chan[c] = (span != 0) ? 8'((a * (span - off) + b * off) / span) : 8'(a);
				end
			end
		end
		r.ramp_position = 17'(where);
		r.out_red = chan[0];
		r.out_green = chan[1];
		r.out_blue = chan[2];
		r.out_alpha = chan[3];
		return r;
	endfunction

	function automatic result_t color_of(int pos, int red, int green, int blue, int alpha);
		result_t r;
		r.ramp_position = 17'(pos);
		r.out_red = 8'(red);
		r.out_green = 8'(green);
		r.out_blue = 8'(blue);
		r.out_alpha = 8'(alpha);
		return r;
	endfunction

	function automatic plan_row_t reg_row(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		plan_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		row.it = '0;
		row.known = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t stop_row(int slot, int pos, int red, int green, int blue,
			int alpha);
		plan_row_t row;
		row = reg_row(CFG_RAMP_MODE, '0);
		row.kind = ROW_STOP;
		row.it.action = ACT_WRITE;
		row.it.stop_index = 4'(slot);
		row.it.stop_position = 17'(pos);
		row.it.stop_red = 8'(red);
		row.it.stop_green = 8'(green);
		row.it.stop_blue = 8'(blue);
		row.it.stop_alpha = 8'(alpha);
		return row;
	endfunction

	function automatic plan_row_t query_row(int x, int y);
		plan_row_t row;
		row = reg_row(CFG_RAMP_MODE, '0);
		row.kind = ROW_QUERY;
		row.it.action = ACT_QUERY;
		row.it.point_x = 16'(x);
		row.it.point_y = 16'(y);
		return row;
	endfunction

	function automatic plan_row_t checked_query(int x, int y, result_t want);
		plan_row_t row;
		row = query_row(x, y);
		row.known = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic void add_row(plan_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic item_t random_item(act_t act);
		item_t it;
		it.action = act;
		it.stop_index = 4'($urandom_range(0, MaxStops - 1));
		it.stop_position = 17'($urandom_range(0, 65536));
		it.stop_red = 8'($urandom_range(0, 255));
		it.stop_green = 8'($urandom_range(0, 255));
		it.stop_blue = 8'($urandom_range(0, 255));
		it.stop_alpha = 8'($urandom_range(0, 255));
		it.point_x = 16'($urandom_range(0, 65535));
		it.point_y = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic logic [15:0] near_edge(logic [15:0] origin, logic [15:0] size);
		int o;
		int s;
		int p;
		o = int'($signed(origin));
		s = int'(size);
		p = o + int'($urandom_range(0, s + s / 4 + 4)) - (s / 8 + 2);
		if (p < -32768)
			p = -32768;
		if (p > 32767)
			p = 32767;
		return 16'(p);
	endfunction

	function automatic logic [CfgDataW-1:0] pick_origin();
		case ($urandom_range(0, 5))
			0: return 17'h08000;
			1: return 17'h07fff;
			2: return 17'(16'(int'($urandom_range(0, 400)) - 200));
			default: return 17'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [CfgDataW-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd65535;
			3, 4: return 17'($urandom_range(0, 65535));
			default: return 17'($urandom_range(2, 600));
		endcase
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < MaxPrinted)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic send_item(item_t it, bit known, result_t want);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		items_sent++;
		if (it.action == ACT_QUERY) begin
			pending_colors.insert(pending_colors.size(), known ? want : lookup_color(it));
		end else begin
			stop_pos[it.stop_index] = it.stop_position;
			stop_rgba[it.stop_index][0] = it.stop_red;
			stop_rgba[it.stop_index][1] = it.stop_green;
			stop_rgba[it.stop_index][2] = it.stop_blue;
			stop_rgba[it.stop_index][3] = it.stop_alpha;
			stop_loaded[it.stop_index] = 1'b1;
		end
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RAMP_MODE: ramp_regs.ramp_mode = val[1:0];
			CFG_ORIGIN_X: ramp_regs.origin_x = val[15:0];
			CFG_ORIGIN_Y: ramp_regs.origin_y = val[15:0];
			CFG_SIZE_X: ramp_regs.size_x = val[15:0];
			CFG_SIZE_Y: ramp_regs.size_y = val[15:0];
			CFG_VALUE_POSITION: ramp_regs.value_position = val[16:0];
			CFG_STOP_COUNT: ramp_regs.stop_count = val[4:0];
			CFG_TEXTURE_VALID: ramp_regs.texture_valid = val[0];
			default: ;
		endcase
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic pause_sender(bit gappy);
		if (gappy && items_sent < ItemTarget - QuietTail && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic run_phase(bit fill_all);
		int n_stops;
		int lead;
		int count;
		int slot;
		int n_queries;
		int positions [$];
		bit gappy;
		bit reverse;
		logic [1:0] mode;
		item_t it;
		result_t none;
		none = '0;
		gappy = ($urandom_range(0, 2) != 0);
		reverse = $urandom_range(0, 1);
		n_stops = fill_all ? MaxStops : $urandom_range(1, MaxStops);
		for (int i = 0; i < n_stops; i++) begin
			case ($urandom_range(0, 9))
				0: positions.insert(positions.size(), 0);
				1: positions.insert(positions.size(), 65536);
				default: positions.insert(positions.size(), int'($urandom_range(0, 65536)));
			endcase
		end
		if ($urandom_range(0, 4) != 0) begin
			positions.sort();
			for (int i = 1; i < n_stops; i++)
				if ($urandom_range(0, 7) == 0)
					positions[i] = positions[i-1];
		end
		lead = 0;
		while (lead < MaxStops && (stop_loaded[lead] || lead < n_stops))
			lead++;
		case ($urandom_range(0, 9))
			0: count = 0;
			1: count = (lead == MaxStops) ? $urandom_range(MaxStops + 1, 31) : lead;
			2: count = $urandom_range(1, lead);
			default: count = n_stops;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mode = MODE_HORIZ;
			4, 5, 6, 7: mode = MODE_VERT;
			8: mode = MODE_VALUE;
			default: mode = ModeReserved;
		endcase

		settle();
		write_register(CFG_RAMP_MODE, 17'(mode));
		write_register(CFG_ORIGIN_X, pick_origin());
		write_register(CFG_ORIGIN_Y, pick_origin());
		write_register(CFG_SIZE_X, pick_size());
		write_register(CFG_SIZE_Y, pick_size());
		write_register(CFG_VALUE_POSITION, ($urandom_range(0, 7) == 0)
				? 17'($urandom_range(65537, 131071)) : 17'($urandom_range(0, 65536)));
		write_register(CFG_STOP_COUNT, 17'(count));
		write_register(CFG_TEXTURE_VALID, 17'($urandom_range(0, 1)));
		cfg_valid <= 1'b0;

		for (int i = 0; i < n_stops; i++) begin
			slot = reverse ? n_stops - 1 - i : i;
			it = random_item(ACT_WRITE);
			it.stop_index = 4'(slot);
			it.stop_position = 17'(positions[slot]);
			send_item(it, 1'b0, none);
			pause_sender(gappy);
		end

		n_queries = $urandom_range(8, 40);
		for (int q = 0; q < n_queries; q++) begin
			if ($urandom_range(0, 9) == 0) begin
				it = random_item(ACT_WRITE);
			end else begin
				it = random_item(ACT_QUERY);
				if ($urandom_range(0, 5) != 0) begin
					it.point_x = near_edge(ramp_regs.origin_x, ramp_regs.size_x);
					it.point_y = near_edge(ramp_regs.origin_y, ramp_regs.size_y);
				end
			end
			send_item(it, 1'b0, none);
			pause_sender(gappy);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_colors.size() == 0) begin
				report_mismatch("result strobe with no query outstanding");
			end else begin
				want = pending_colors.pop_front();
				if (result.ramp_position !== want.ramp_position)
					report_mismatch($sformatf("ramp_position %0d, expected %0d",
							result.ramp_position, want.ramp_position));
				if (result.out_red !== want.out_red)
					report_mismatch($sformatf("out_red %0d, expected %0d",
							result.out_red, want.out_red));
				if (result.out_green !== want.out_green)
					report_mismatch($sformatf("out_green %0d, expected %0d",
							result.out_green, want.out_green));
				if (result.out_blue !== want.out_blue)
					report_mismatch($sformatf("out_blue %0d, expected %0d",
							result.out_blue, want.out_blue));
				if (result.out_alpha !== want.out_alpha)
					report_mismatch($sformatf("out_alpha %0d, expected %0d",
							result.out_alpha, want.out_alpha));
			end
		end
	end

	initial begin
		#5000000;
		$display("gradient_color_ramp_lookup regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ramp_regs = '{ramp_mode: MODE_VALUE, origin_x: '0, origin_y: '0, size_x: 16'd1,
				size_y: 16'd1, value_position: '0, stop_count: '0, texture_valid: 1'b0};

		add_row(checked_query(0, 0, color_of(0, 0, 0, 0, 0)));
		add_row(reg_row(CFG_TEXTURE_VALID, 17'd1));
		add_row(checked_query(0, 0, color_of(0, 255, 255, 255, 255)));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h1ffff));
		add_row(checked_query(0, 0, color_of(65536, 255, 255, 255, 255)));
		add_row(stop_row(0, 17'h04000, 10, 20, 30, 40));
		add_row(stop_row(1, 17'h08000, 255, 0, 255, 0));
		add_row(stop_row(2, 17'h08000, 1, 2, 3, 4));
		add_row(stop_row(3, 17'h10000, 0, 255, 128, 255));
		add_row(reg_row(CFG_STOP_COUNT, 17'd4));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h00000));
		add_row(checked_query(0, 0, color_of(0, 10, 20, 30, 40)));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h04000));
		add_row(checked_query(0, 0, color_of(16384, 10, 20, 30, 40)));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h06000));
		add_row(query_row(0, 0));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h10000));
		add_row(query_row(0, 0));
		add_row(reg_row(CFG_STOP_COUNT, 17'd3));
		add_row(checked_query(0, 0, color_of(65536, 1, 2, 3, 4)));
		add_row(reg_row(CFG_RAMP_MODE, 17'(MODE_HORIZ)));
		add_row(reg_row(CFG_ORIGIN_X, 17'h08000));
		add_row(reg_row(CFG_SIZE_X, 17'd65535));
		add_row(checked_query(32767, 0, color_of(65536, 1, 2, 3, 4)));
		add_row(checked_query(-32768, 0, color_of(0, 10, 20, 30, 40)));
		add_row(query_row(0, 0));
		add_row(reg_row(CFG_SIZE_X, 17'd0));
		add_row(checked_query(-32767, 0, color_of(65536, 1, 2, 3, 4)));
		add_row(checked_query(-32768, 0, color_of(0, 10, 20, 30, 40)));
		add_row(reg_row(CFG_RAMP_MODE, 17'(MODE_VERT)));
		add_row(reg_row(CFG_ORIGIN_Y, 17'h07fff));
		add_row(reg_row(CFG_SIZE_Y, 17'd1));
		add_row(checked_query(0, 32767, color_of(0, 10, 20, 30, 40)));
		add_row(checked_query(0, -32768, color_of(0, 10, 20, 30, 40)));
		add_row(reg_row(CFG_ORIGIN_Y, 17'h0ff9c));
		add_row(reg_row(CFG_SIZE_Y, 17'd300));
		add_row(query_row(0, 50));
		add_row(reg_row(CFG_RAMP_MODE, 17'(ModeReserved)));
		add_row(reg_row(CFG_VALUE_POSITION, 17'h07000));
		add_row(query_row(0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_register(plan[i].reg_idx, plan[i].reg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_item(plan[i].it, plan[i].known, plan[i].want);
			end
		end

		run_phase(1'b1);
		while (items_sent < ItemTarget)
			run_phase(1'b0);

		start <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("gradient_color_ramp_lookup regression: pass");
		else
			$display("gradient_color_ramp_lookup regression: fail");
		$finish;
	end

endmodule

// ===== gradient_color_ramp_lookup.f =====
+incdir+rtl/core
rtl/core/gcr_pkg.sv
rtl/core/gcr_ram.sv
rtl/core/gcr_div_step.sv
rtl/core/gcr_engine.sv
rtl/core/gradient_color_ramp_lookup.sv
tb/tb_gradient_color_ramp_lookup.sv
